[hdl/jlt_pkg.sv]
`default_nettype none

package jlt_pkg;

    // Record kinds on the result channel.
    localparam logic KIND_CONTENT = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Token classes.
    localparam logic [3:0] CLS_STRING  = 4'd0;
    localparam logic [3:0] CLS_NUMERIC = 4'd1;
    localparam logic [3:0] CLS_BOOLEAN = 4'd2;
    localparam logic [3:0] CLS_NULL    = 4'd3;
    localparam logic [3:0] CLS_LBRACE  = 4'd4;
    localparam logic [3:0] CLS_RBRACE  = 4'd5;
    localparam logic [3:0] CLS_LBRACK  = 4'd6;
    localparam logic [3:0] CLS_RBRACK  = 4'd7;
    localparam logic [3:0] CLS_COLON   = 4'd8;
    localparam logic [3:0] CLS_COMMA   = 4'd9;
    localparam logic [3:0] CLS_EMPTY   = 4'd10;

    // Characters with a meaning to the lexer.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // Keyword index in the candidate mask.
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;
    localparam int         NUM_KW   = 3;

    // One result record, length carried separately (its width follows the limit).
    typedef struct packed {
        logic       kind;
        logic [7:0] content_byte;
        logic [3:0] token_class;
        logic       overflow;
        logic       last;
    } res_t;

    // Punctuation class, CLS_STRING when the byte is not punctuation.
    function automatic logic [3:0] punct_class(input logic [7:0] b);
        logic [3:0] c;
        c = CLS_STRING;
        unique case (b)
            CH_LBRACE: c = CLS_LBRACE;
            CH_RBRACE: c = CLS_RBRACE;
            CH_LBRACK: c = CLS_LBRACK;
            CH_RBRACK: c = CLS_RBRACK;
            CH_COLON:  c = CLS_COLON;
            CH_COMMA:  c = CLS_COMMA;
            default:   c = CLS_STRING;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return is_digit(b) || ((b >= 8'h41) && (b <= 8'h5A)) ||
               ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic [3:0] kw_len(input logic [1:0] k);
        logic [3:0] l;
        l = 4'd0;
        unique case (k)
            KW_TRUE:  l = 4'd4;
            KW_FALSE: l = 4'd5;
            KW_NULL:  l = 4'd4;
            default:  l = 4'd0;
        endcase
        return l;
    endfunction

    // Character at position pos of keyword k.
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [39:0] txt;
        logic [7:0]  c;
        txt = '0;
        unique case (k)
            KW_TRUE:  txt = {8'h74, 8'h72, 8'h75, 8'h65, 8'h00};
            KW_FALSE: txt = {8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};
            KW_NULL:  txt = {8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00};
            default:  txt = '0;
        endcase
        c = 8'h00;
        case (pos)
            3'd0:    c = txt[39:32];
            3'd1:    c = txt[31:24];
            3'd2:    c = txt[23:16];
            3'd3:    c = txt[15:8];
            3'd4:    c = txt[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/json_lite_tokenizer.sv]
`default_nettype none

// Simplified JSON lexer, one byte per input transaction. Each byte yields zero
// to three result transactions: content records (kind 0) for every byte kept in
// the current token, and an end record (kind 1) with class, length and overflow
// flag when a token closes; "last" marks the final record of a byte. The lexer
// state and all records of a byte are worked out combinationally and written
// into a four-entry result queue, so a byte enters every cycle as long as the
// output side keeps up; the block stalls input only while more than one queued
// record is still waiting. Sustained throughput is therefore set by the result
// records: one byte per cycle for bytes that give at most one record, while a
// byte that closes a word and forms a punctuation token stalls the next byte.
// Tokens keep at most MAX_TOKEN_LEN bytes; token_len is sized to hold that limit.
module json_lite_tokenizer import jlt_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 256
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [7:0]                           char_in,
    // result channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      kind,
    output logic [7:0]                                content_byte,
    output logic [3:0]                                token_class,
    output logic [$clog2(MAX_TOKEN_LEN+1)-1:0]        token_len,
    output logic                                      overflow,
    output logic                                      last
);

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
    localparam int RW = $bits(res_t) + LW;

    logic          in_accept;
    logic          pop;
    logic [1:0]    push_cnt;
    res_t          res [3];
    logic [LW-1:0] res_len [3];
    logic [RW-1:0] push_data [3];
    logic [RW-1:0] head;
    logic [2:0]    count;
    logic [2:0]    count_after_pop;
    res_t          head_res;

    // Queue occupancy once this cycle's pop is done; a byte can add up to three.
    assign count_after_pop = count - {2'b00, pop};
    assign in_stall        = (count_after_pop > 3'd1);
    assign in_accept       = in_valid && !in_stall;

    jlt_lexer #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_accept),
        .char_in  (char_in),
        .push_cnt (push_cnt),
        .res      (res),
        .res_len  (res_len)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            push_data[i] = {res[i], res_len[i]};
        end
    end

    jlt_res_fifo #(
        .WIDTH (RW)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .count     (count)
    );

    assign out_valid    = (count != 3'd0);
    assign pop          = out_valid && !out_stall;
    assign head_res     = head[RW-1:LW];
    assign token_len    = head[LW-1:0];
    assign kind         = head_res.kind;
    assign content_byte = head_res.content_byte;
    assign token_class  = head_res.token_class;
    assign overflow     = head_res.overflow;
    assign last         = head_res.last;

    // Queue never holds more than its four entries.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= 3'd4)
        else $error("result queue over capacity");

    // Input is held back only while results are pending.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty result queue");

    // A record without last is followed by more records of the same byte.
    a_last_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("records of a byte ended without last");

    // End records never report more than the length limit.
    a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_END)) |-> (token_len <= LW'(MAX_TOKEN_LEN)))
        else $error("token length above limit");

endmodule

`default_nettype wire

[hdl/jlt_res_fifo.sv]
`default_nettype none

// Four-entry result queue, up to three writes and one read per cycle.
module jlt_res_fifo #(
    parameter int WIDTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       push_cnt,
    input  wire logic [WIDTH-1:0] push_data [3],
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head,
    output logic [2:0]            count
);

    localparam int DEPTH = 4;
    localparam int SLOTS = 3;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [1:0]       wr_ptr_reg, wr_ptr_next;
    logic [1:0]       rd_ptr_reg, rd_ptr_next;
    logic [2:0]       count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (2'(i) < push_cnt)
            begin
                mem_reg[wr_ptr_reg + 2'(i)] <= push_data[i];
            end
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

[hdl/jlt_lexer.sv]
`default_nettype none

// Lexer state and the result records of one byte, in one pass.
module jlt_lexer import jlt_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   accept,
    input  wire logic [7:0]                             char_in,
    output logic [1:0]                                  push_cnt,
    output res_t                                        res [3],
    output logic [$clog2(MAX_TOKEN_LEN+1)-1:0]          res_len [3]
);

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

    typedef struct packed {
        logic [LW-1:0] plen;
        logic          alld;
        logic [2:0]    cand;
        logic          trunc;
    } tok_t;

    localparam tok_t TOK_CLEAN = '{plen: '0, alld: 1'b1, cand: 3'b111, trunc: 1'b0};

    tok_t tok_reg, tok_next;
    logic inq_reg, inq_next;
    logic qjo_reg, qjo_next;

    function automatic tok_t do_append(input tok_t s, input logic [7:0] b, output logic emit);
        tok_t t;
        t = s;
        emit = 1'b0;
        if (s.plen >= LW'(MAX_TOKEN_LEN))
        begin
            t.trunc = 1'b1;
        end
        else
        begin
            if (!is_digit(b))
            begin
                t.alld = 1'b0;
            end
            for (int k = 0; k < NUM_KW; k++)
            begin
                if (s.cand[k] && ((s.plen >= LW'(kw_len(2'(k)))) ||
                                  (kw_char(2'(k), s.plen[2:0]) != b)))
                begin
                    t.cand[k] = 1'b0;
                end
            end
            t.plen = s.plen + LW'(1);
            emit   = 1'b1;
        end
        return t;
    endfunction

    function automatic logic [3:0] fin_class(input tok_t s, input logic [3:0] cls);
        logic [3:0] c;
        c = cls;
        if ((s.plen != '0) && s.alld)
        begin
            c = CLS_NUMERIC;
        end
        else if ((s.cand[KW_TRUE] && (s.plen == LW'(4))) ||
                 (s.cand[KW_FALSE] && (s.plen == LW'(5))))
        begin
            c = CLS_BOOLEAN;
        end
        else if (s.cand[KW_NULL] && (s.plen == LW'(4)))
        begin
            c = CLS_NULL;
        end
        return c;
    endfunction

    always_comb
    begin
        tok_t       s;
        logic [1:0] n;
        logic [3:0] pc;
        logic       emit;
        logic [7:0] ab;
        logic       do_fin;
        logic [3:0] fcls;

        s        = tok_reg;
        n        = '0;
        pc       = punct_class(char_in);
        emit     = 1'b0;
        ab       = char_in;
        do_fin   = 1'b0;
        fcls     = CLS_STRING;
        inq_next = inq_reg;
        qjo_next = qjo_reg;
        for (int i = 0; i < 3; i++)
        begin
            res[i]     = '0;
            res_len[i] = '0;
        end

        if (inq_reg)
        begin
            if (char_in == CH_QUOTE)
            begin
                if (qjo_reg)
                begin
                    // empty string: two quote bytes, forced end record
                    s = do_append(s, CH_QUOTE, emit);
                    if (emit)
                    begin
                        res[n].kind         = KIND_CONTENT;
                        res[n].content_byte = CH_QUOTE;
                        n = n + 2'd1;
                    end
                    s = do_append(s, CH_QUOTE, emit);
                    if (emit)
                    begin
                        res[n].kind         = KIND_CONTENT;
                        res[n].content_byte = CH_QUOTE;
                        n = n + 2'd1;
                    end
                    do_fin = 1'b1;
                    fcls   = CLS_EMPTY;
                end
                else
                begin
                    do_fin = (s.plen != '0);
                    fcls   = CLS_STRING;
                end
                inq_next = 1'b0;
                qjo_next = 1'b0;
            end
            else
            begin
                s = do_append(s, char_in, emit);
                if (emit)
                begin
                    res[n].kind         = KIND_CONTENT;
                    res[n].content_byte = char_in;
                    n = n + 2'd1;
                end
                qjo_next = 1'b0;
            end
        end
        else if (pc != CLS_STRING)
        begin
            // close the pending word, then the one-byte punctuation token
            if (s.plen != '0)
            begin
                res[n].kind        = KIND_END;
                res[n].token_class = fin_class(s, CLS_STRING);
                res[n].overflow    = s.trunc;
                res_len[n]         = s.plen;
                n = n + 2'd1;
                s = TOK_CLEAN;
            end
            s = do_append(s, ab, emit);
            if (emit)
            begin
                res[n].kind         = KIND_CONTENT;
                res[n].content_byte = ab;
                n = n + 2'd1;
            end
            do_fin = (s.plen != '0);
            fcls   = pc;
        end
        else if (is_alnum(char_in))
        begin
            s = do_append(s, char_in, emit);
            if (emit)
            begin
                res[n].kind         = KIND_CONTENT;
                res[n].content_byte = char_in;
                n = n + 2'd1;
            end
        end
        else if (char_in == CH_NUL)
        begin
            do_fin   = (s.plen != '0);
            fcls     = CLS_STRING;
            qjo_next = 1'b0;
        end
        else if (char_in == CH_QUOTE)
        begin
            inq_next = 1'b1;
            qjo_next = 1'b1;
        end

        if (do_fin)
        begin
            res[n].kind        = KIND_END;
            res[n].token_class = fin_class(s, fcls);
            res[n].overflow    = s.trunc;
            res_len[n]         = s.plen;
            n = n + 2'd1;
            s = TOK_CLEAN;
        end
        if ((char_in == CH_NUL) && !inq_reg)
        begin
            s = TOK_CLEAN;
        end

        if (n != '0)
        begin
            res[n - 2'd1].last = 1'b1;
        end

        tok_next = s;
        push_cnt = accept ? n : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= TOK_CLEAN;
            inq_reg <= 1'b0;
            qjo_reg <= 1'b0;
        end
        else if (accept)
        begin
            tok_reg <= tok_next;
            inq_reg <= inq_next;
            qjo_reg <= qjo_next;
        end
    end

endmodule

`default_nettype wire
